FILE: sv/spd_pkg.sv
// Package: phase codes, status codes, register indexes and the CRC16-CCITT byte update.
package spd_pkg;

   typedef enum logic [8:0] {
      PH_HUNT  = 9'b000000001,
      PH_SYNC2 = 9'b000000010,
      PH_TYPE  = 9'b000000100,
      PH_SEQ   = 9'b000001000,
      PH_LENLO = 9'b000010000,
      PH_LENHI = 9'b000100000,
      PH_PAY   = 9'b001000000,
      PH_CRCLO = 9'b010000000,
      PH_CRCHI = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      ST_MORE     = 2'd0,
      ST_OK       = 2'd1,
      ST_CRC_FAIL = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_MAX_LENGTH  = 2'd2
   } csr_index_type;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0]  SYNC_FIRST_RST  = 8'd45;
   localparam logic [7:0]  SYNC_SECOND_RST = 8'd212;
   localparam logic [15:0] MAX_LENGTH_RST  = 16'd255;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/sync_packet_deframer_crc16.sv
// Top level: sync-word packet deframer with CRC16-CCITT check, one word in, one word out.
//
//   channel  direction  ports
//   req      in         req_valid req_ready req_rx_byte
//   rsp      out        rsp_valid rsp_ready rsp_status rsp_payload_valid rsp_payload_index
//                       rsp_payload_byte rsp_frame_type rsp_sequence_res rsp_frame_length
//   csr      in         csr_valid csr_ready csr_index csr_data
//
// The result of an accepted word is registered and shows on rsp in the cycle after it is accepted.
// A new word is taken every cycle while the result register is empty or being drained.
// A stalled rsp side holds the result register and drops req_ready until it is taken.
// Synchronous reset returns the frame state to hunting and the csr registers to defaults.
// csr writes are always taken: csr_ready is tied high.
module sync_packet_deframer_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_payload_valid,
   output logic [15:0] rsp_payload_index,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_frame_type,
   output logic [7:0]  rsp_sequence_res,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [7:0]  sync_first_ff, sync_first_in;
   logic [7:0]  sync_second_ff, sync_second_in;
   logic [15:0] max_length_ff, max_length_in;

   spd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic        pv_ff, pv_in;
   logic [15:0] pidx_ff, pidx_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic [7:0]  ft_ff, ft_in;
   logic [7:0]  sq_ff, sq_in;
   logic [15:0] fl_ff, fl_in;

   logic        accept;
   logic [15:0] crc_next;
   logic [15:0] crc_seed;
   logic [15:0] length_full;
   logic [15:0] count_inc;
   logic        restart;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign crc_next    = spd_pkg::crc_byte(crc_ff, req_rx_byte);
   assign crc_seed    = spd_pkg::crc_byte(spd_pkg::CRC_INIT, req_rx_byte);
   assign length_full = {req_rx_byte, length_ff[7:0]};
   assign count_inc   = count_ff + 16'd1;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      max_length_in  = max_length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            spd_pkg::CSR_SYNC_FIRST:  sync_first_in  = csr_data[7:0];
            spd_pkg::CSR_SYNC_SECOND: sync_second_in = csr_data[7:0];
            spd_pkg::CSR_MAX_LENGTH:  max_length_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      count_in  = count_ff;
      type_in   = type_ff;
      seq_in    = seq_ff;
      length_in = length_ff;
      crc_lo_in = crc_lo_ff;
      status_in = spd_pkg::ST_MORE;
      pv_in     = 1'b0;
      pidx_in   = 16'd0;
      pbyte_in  = 8'd0;
      restart   = 1'b0;

      unique case (phase_ff)
         spd_pkg::PH_SYNC2: begin
            if (req_rx_byte == sync_second_ff) begin
               crc_in   = crc_next;
               phase_in = spd_pkg::PH_TYPE;
            end else if (req_rx_byte == sync_first_ff) begin
               crc_in = crc_seed;
            end else begin
               phase_in = spd_pkg::PH_HUNT;
            end
         end
         spd_pkg::PH_TYPE: begin
            type_in  = req_rx_byte;
            crc_in   = crc_next;
            phase_in = spd_pkg::PH_SEQ;
         end
         spd_pkg::PH_SEQ: begin
            seq_in   = req_rx_byte;
            crc_in   = crc_next;
            phase_in = spd_pkg::PH_LENLO;
         end
         spd_pkg::PH_LENLO: begin
            length_in = {8'd0, req_rx_byte};
            crc_in    = crc_next;
            phase_in  = spd_pkg::PH_LENHI;
         end
         spd_pkg::PH_LENHI: begin
            length_in = length_full;
            crc_in    = crc_next;
            if (length_full > max_length_ff) begin
               status_in = spd_pkg::ST_OVERFLOW;
               restart   = 1'b1;
            end else begin
               count_in = 16'd0;
               phase_in = (length_full != 16'd0) ? spd_pkg::PH_PAY : spd_pkg::PH_CRCLO;
            end
         end
         spd_pkg::PH_PAY: begin
            pv_in    = 1'b1;
            pidx_in  = count_ff;
            pbyte_in = req_rx_byte;
            crc_in   = crc_next;
            count_in = count_inc;
            if (count_inc == length_ff) begin
               phase_in = spd_pkg::PH_CRCLO;
            end
         end
         spd_pkg::PH_CRCLO: begin
            crc_lo_in = req_rx_byte;
            phase_in  = spd_pkg::PH_CRCHI;
         end
         spd_pkg::PH_CRCHI: begin
            status_in = ({req_rx_byte, crc_lo_ff} == crc_ff) ? spd_pkg::ST_OK
                                                             : spd_pkg::ST_CRC_FAIL;
            restart   = 1'b1;
         end
         default: begin
            if (req_rx_byte == sync_first_ff) begin
               crc_in   = crc_seed;
               phase_in = spd_pkg::PH_SYNC2;
            end else begin
               phase_in = spd_pkg::PH_HUNT;
            end
         end
      endcase

      ft_in = type_in;
      sq_in = seq_in;
      fl_in = length_in;

      if (restart) begin
         phase_in  = spd_pkg::PH_HUNT;
         crc_in    = spd_pkg::CRC_INIT;
         count_in  = 16'd0;
         type_in   = 8'd0;
         seq_in    = 8'd0;
         length_in = 16'd0;
         crc_lo_in = 8'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= spd_pkg::SYNC_FIRST_RST;
         sync_second_ff <= spd_pkg::SYNC_SECOND_RST;
         max_length_ff  <= spd_pkg::MAX_LENGTH_RST;
         phase_ff       <= spd_pkg::PH_HUNT;
         crc_ff         <= spd_pkg::CRC_INIT;
         count_ff       <= 16'd0;
         type_ff        <= 8'd0;
         seq_ff         <= 8'd0;
         length_ff      <= 16'd0;
         crc_lo_ff      <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         max_length_ff  <= max_length_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            crc_ff    <= crc_in;
            count_ff  <= count_in;
            type_ff   <= type_in;
            seq_ff    <= seq_in;
            length_ff <= length_in;
            crc_lo_ff <= crc_lo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         pv_ff     <= pv_in;
         pidx_ff   <= pidx_in;
         pbyte_ff  <= pbyte_in;
         ft_ff     <= ft_in;
         sq_ff     <= sq_in;
         fl_ff     <= fl_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_payload_valid = pv_ff;
   assign rsp_payload_index = pidx_ff;
   assign rsp_payload_byte  = pbyte_ff;
   assign rsp_frame_type    = ft_ff;
   assign rsp_sequence_res  = sq_ff;
   assign rsp_frame_length  = fl_ff;

endmodule

FILE: bench/sync_packet_deframer_crc16_test.sv
// Testbench for the sync-word packet deframer: directed and random framed byte streams checked by a predictor.
`timescale 1ns / 1ps

module sync_packet_deframer_crc16_test;

   typedef struct packed {
      spd_pkg::status_type status;
      logic        pay_valid;
      logic [15:0] pay_index;
      logic [7:0]  pay_byte;
      logic [7:0]  ftype;
      logic [7:0]  seq;
      logic [15:0] flen;
   } deframe_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_payload_valid;
   logic [15:0] rsp_payload_index;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_frame_type;
   logic [7:0]  rsp_sequence_res;
   logic [15:0] rsp_frame_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent = 0;
   int errors = 0;

   logic [7:0]  cfg_sync_first = spd_pkg::SYNC_FIRST_RST;
   logic [7:0]  cfg_sync_second = spd_pkg::SYNC_SECOND_RST;
   logic [15:0] cfg_max_length = spd_pkg::MAX_LENGTH_RST;

   spd_pkg::phase_type ph = spd_pkg::PH_HUNT;
   logic [15:0] crc_acc = 16'hFFFF;
   logic [15:0] pay_count = '0;
   logic [7:0]  type_q = '0;
   logic [7:0]  seq_q = '0;
   logic [15:0] len_q = '0;
   logic [15:0] crc_rx = '0;

   deframe_word_type pending_words[$];

   sync_packet_deframer_crc16 i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_sequence_res  (rsp_sequence_res),
      .rsp_frame_length  (rsp_frame_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAIL sync_packet_deframer_crc16");
      $finish;
   end

   function automatic logic [15:0] crc_ccitt_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
      end
      return c;
   endfunction

   function automatic deframe_word_type deframe_byte(input logic [7:0] b);
      deframe_word_type w;
      logic             done;
      w = '0;
      w.status = spd_pkg::ST_MORE;
      done = 1'b0;
      case (ph)
         spd_pkg::PH_SYNC2: begin
            if (b == cfg_sync_second) begin
               crc_acc = crc_ccitt_update(crc_acc, b);
               ph = spd_pkg::PH_TYPE;
            end else if (b == cfg_sync_first) begin
               crc_acc = crc_ccitt_update(16'hFFFF, b);
            end else begin
               ph = spd_pkg::PH_HUNT;
            end
         end
         spd_pkg::PH_TYPE: begin
            type_q = b;
            crc_acc = crc_ccitt_update(crc_acc, b);
            ph = spd_pkg::PH_SEQ;
         end
         spd_pkg::PH_SEQ: begin
            seq_q = b;
            crc_acc = crc_ccitt_update(crc_acc, b);
            ph = spd_pkg::PH_LENLO;
         end
         spd_pkg::PH_LENLO: begin
            len_q = {8'h00, b};
            crc_acc = crc_ccitt_update(crc_acc, b);
            ph = spd_pkg::PH_LENHI;
         end
         spd_pkg::PH_LENHI: begin
            len_q = {b, len_q[7:0]};
            crc_acc = crc_ccitt_update(crc_acc, b);
            if (len_q > cfg_max_length) begin
               w.status = spd_pkg::ST_OVERFLOW;
               done = 1'b1;
            end else begin
               pay_count = '0;
               ph = (len_q != 16'd0) ? spd_pkg::PH_PAY : spd_pkg::PH_CRCLO;
            end
         end
         spd_pkg::PH_PAY: begin
            w.pay_valid = 1'b1;
            w.pay_index = pay_count;
            w.pay_byte = b;
            crc_acc = crc_ccitt_update(crc_acc, b);
            pay_count = pay_count + 16'd1;
            if (pay_count == len_q) begin
               ph = spd_pkg::PH_CRCLO;
            end
         end
         spd_pkg::PH_CRCLO: begin
            crc_rx = {8'h00, b};
            ph = spd_pkg::PH_CRCHI;
         end
         spd_pkg::PH_CRCHI: begin
            crc_rx = {b, crc_rx[7:0]};
            w.status = (crc_rx == crc_acc) ? spd_pkg::ST_OK : spd_pkg::ST_CRC_FAIL;
            done = 1'b1;
         end
         default: begin
            if (b == cfg_sync_first) begin
               crc_acc = crc_ccitt_update(16'hFFFF, b);
               ph = spd_pkg::PH_SYNC2;
            end else begin
               ph = spd_pkg::PH_HUNT;
            end
         end
      endcase
      w.ftype = type_q;
      w.seq = seq_q;
      w.flen = len_q;
      if (done) begin
         ph = spd_pkg::PH_HUNT;
         crc_acc = 16'hFFFF;
         pay_count = '0;
         type_q = '0;
         seq_q = '0;
         len_q = '0;
         crc_rx = '0;
      end
      return w;
   endfunction

   task automatic log_mismatch(input string msg);
      errors++;
      $display("%0t mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_results
      deframe_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            log_mismatch("result word with nothing pending");
         end else begin
            want = pending_words.pop_front();
            if (rsp_status !== want.status)
               log_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_payload_valid !== want.pay_valid)
               log_mismatch($sformatf("payload_valid %0b, want %0b",
                                      rsp_payload_valid, want.pay_valid));
            if (rsp_payload_index !== want.pay_index)
               log_mismatch($sformatf("payload_index %0d, want %0d",
                                      rsp_payload_index, want.pay_index));
            if (rsp_payload_byte !== want.pay_byte)
               log_mismatch($sformatf("payload_byte %h, want %h",
                                      rsp_payload_byte, want.pay_byte));
            if (rsp_frame_type !== want.ftype)
               log_mismatch($sformatf("frame_type %h, want %h", rsp_frame_type, want.ftype));
            if (rsp_sequence_res !== want.seq)
               log_mismatch($sformatf("sequence_res %h, want %h", rsp_sequence_res, want.seq));
            if (rsp_frame_length !== want.flen)
               log_mismatch($sformatf("frame_length %h, want %h",
                                      rsp_frame_length, want.flen));
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_words.push_back(deframe_byte(b));
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] seq,
                             input logic [15:0] len, input bit bad_crc);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = 16'hFFFF;
      crc = crc_ccitt_update(crc, cfg_sync_first);
      send_byte(cfg_sync_first);
      crc = crc_ccitt_update(crc, cfg_sync_second);
      send_byte(cfg_sync_second);
      crc = crc_ccitt_update(crc, ftype);
      send_byte(ftype);
      crc = crc_ccitt_update(crc, seq);
      send_byte(seq);
      crc = crc_ccitt_update(crc, len[7:0]);
      send_byte(len[7:0]);
      crc = crc_ccitt_update(crc, len[15:8]);
      send_byte(len[15:8]);
      if (len <= cfg_max_length) begin
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            crc = crc_ccitt_update(crc, b);
            send_byte(b);
         end
         if (bad_crc) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
         end
         send_byte(crc[7:0]);
         send_byte(crc[15:8]);
      end
   endtask

   task automatic flush_to_hunt();
      logic [7:0] b;
      while (ph != spd_pkg::PH_HUNT) begin
         do b = 8'($urandom_range(255)); while (b == cfg_sync_first);
         send_byte(b);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss,
                               input logic [15:0] ml);
      spd_pkg::csr_index_type idx;
      idx = spd_pkg::CSR_SYNC_FIRST;
      repeat (3) begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         case (idx)
            spd_pkg::CSR_SYNC_FIRST:  csr_data <= {8'h00, sf};
            spd_pkg::CSR_SYNC_SECOND: csr_data <= {8'h00, ss};
            default:                  csr_data <= ml;
         endcase
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         idx = idx.next();
      end
      csr_valid <= 1'b0;
      cfg_sync_first = sf;
      cfg_sync_second = ss;
      cfg_max_length = ml;
   endtask

   task automatic test_directed();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cfg_sync_first);
      send_byte(8'h00);
      // repeated first sync byte restarts the match
      send_byte(cfg_sync_first);
      send_frame(8'hFF, 8'h00, 16'd0, 1'b0);
      send_frame(8'h00, 8'hFF, 16'd1, 1'b1);
      send_frame(8'hA5, 8'h5A, 16'd256, 1'b0);
      wait_idle();
   endtask

   task automatic test_equal_sync();
      program_regs(8'h7E, 8'h7E, 16'd8);
      send_frame(8'h7E, 8'h7E, 16'd3, 1'b0);
      send_byte(8'h7E);
      send_frame(8'h7E, 8'h01, 16'd2, 1'b0);
      flush_to_hunt();
      wait_idle();
   endtask

   task automatic test_length_limits();
      program_regs(8'h00, 8'hFF, 16'd0);
      send_frame(8'h12, 8'h34, 16'd0, 1'b0);
      send_frame(8'h56, 8'h78, 16'd1, 1'b0);
      send_frame(8'h9A, 8'hBC, 16'hFFFF, 1'b0);
      wait_idle();
      program_regs(8'hFF, 8'h00, 16'hFFFF);
      send_frame(8'hDE, 8'hAD, 16'd256, 1'b0);
      send_frame(8'hBE, 8'hEF, 16'd5, 1'b1);
      wait_idle();
      program_regs(8'hC3, 8'h3C, 16'h8000);
      send_frame(8'h01, 8'h80, 16'h8001, 1'b0);
      send_frame(8'h02, 8'h40, 16'd4, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int n);
      logic [7:0]  sf;
      logic [7:0]  ss;
      logic [15:0] lim;
      int          r;
      int          stop_at;
      sf = 8'($urandom_range(255));
      ss = ($urandom_range(9) == 0) ? sf : 8'($urandom_range(255));
      program_regs(sf, ss, 16'($urandom_range(48)));
      lim = (cfg_max_length > 16'd48) ? 16'd48 : cfg_max_length;
      stop_at = bytes_sent + n;
      while (bytes_sent < stop_at) begin
         r = $urandom_range(99);
         flush_to_hunt();
         if (r < 75) begin
            if ($urandom_range(7) == 0) begin
               send_byte(cfg_sync_first);
            end
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                       16'($urandom_range(lim)), (r >= 65));
         end else if (r < 83) begin
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                       16'($urandom_range(65535, cfg_max_length + 1)), 1'b0);
         end else if (r < 91) begin
            send_byte(cfg_sync_first);
            if ($urandom_range(1)) send_byte(cfg_sync_second);
            repeat ($urandom_range(5)) send_byte(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
         end
      end
      flush_to_hunt();
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 6;
      recv_idle_pct = 80;
      test_directed();
      test_equal_sync();
      test_random_traffic(250);

      send_idle_pct = 80;
      recv_idle_pct = 6;
      test_length_limits();
      test_random_traffic(250);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(250);

      if (errors == 0) begin
         $display("PASS sync_packet_deframer_crc16");
      end else begin
         $display("FAIL sync_packet_deframer_crc16");
      end
      $finish;
   end

endmodule
